[src/lpra_pkg.sv]
// Shared codes of the label pool range allocator: request types and status values.
package lpra_pkg;
	localparam logic [2:0] REQ_ALLOC_LABEL   = 3'd0;
	localparam logic [2:0] REQ_RESERVE_LABEL = 3'd1;
	localparam logic [2:0] REQ_RELEASE_LABEL = 3'd2;
	localparam logic [2:0] REQ_ALLOC_RANGE   = 3'd3;
	localparam logic [2:0] REQ_RESERVE_RANGE = 3'd4;
	localparam logic [2:0] REQ_RELEASE_RANGE = 3'd5;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_INVALID     = 4'd1;
	localparam logic [3:0] ST_RANGE       = 4'd2;
	localparam logic [3:0] ST_IN_USE      = 4'd3;
	localparam logic [3:0] ST_BUSY        = 4'd4;
	localparam logic [3:0] ST_NONE_FREE   = 4'd5;
	localparam logic [3:0] ST_NOT_FOUND   = 4'd6;
	localparam logic [3:0] ST_WRONG_OWNER = 4'd7;
	localparam logic [3:0] ST_TABLE_FULL  = 4'd8;

	typedef logic [3:0] status_t;
endpackage

[src/lpra_ram.sv]
// Generic simple dual-port RAM with registered read.
module lpra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[src/label_pool_range_allocator_unit.sv]
// Label pool range allocator: used-bit bitmap and owner record table under a scan sequencer.
//
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall | req_type client_type client_id label count
//  out     | output    | out_valid/out_stall | status out_label allocated_total record_total
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (label_base)
//
// One request at a time; a shared scan counter walks the bitmap RAM or record RAM one
// entry per cycle. Alloc: free-run scan, free-slot scan, record write, bit marking;
// reserve: bit check, free-slot scan, record write, bit marking; release: record find,
// owner check, bit clearing. After reset a clearing pass runs before in opens.
// A result waits in the output register; the next word is taken while it stalls.
module label_pool_range_allocator_unit #(
	parameter int POOL_SIZE        = 4096,
	parameter int MAX_RECORDS      = 256,
	parameter int NUM_CLIENT_TYPES = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [3:0]        client_type,
	input  logic [31:0]       client_id,
	input  logic [19:0]       label,
	input  logic [12:0]       count,
	output logic              out_valid,
	input  logic              out_stall,
	output lpra_pkg::status_t status,
	output logic [19:0]       out_label,
	output logic [12:0]       allocated_total,
	output logic [8:0]        record_total,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [19:0]       cfg_data
);
	import lpra_pkg::*;

	localparam int PW    = $clog2(POOL_SIZE);
	localparam int LW    = $clog2(POOL_SIZE + 1);
	localparam int RW    = $clog2(MAX_RECORDS);
	localparam int CW    = $clog2(MAX_RECORDS + 1);
	localparam int CLR_N = (POOL_SIZE > MAX_RECORDS) ? POOL_SIZE : MAX_RECORDS;
	localparam int SW    = $clog2(CLR_N) + 1;
	localparam int RECW  = PW + LW + 4 + 32;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_FIT  = 4'd3;
	localparam logic [3:0] S_RUN  = 4'd4;
	localparam logic [3:0] S_SLOT = 4'd5;
	localparam logic [3:0] S_FIND = 4'd6;
	localparam logic [3:0] S_OWN  = 4'd7;
	localparam logic [3:0] S_WR   = 4'd8;
	localparam logic [3:0] S_MARK = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]    state_q;
	logic [SW-1:0] clr_q, sp_q, end_q;
	logic [19:0]   base_q;
	logic [2:0]    req_q;
	logic [3:0]    ctype_q;
	logic [31:0]   cid_q;
	logic [19:0]   lab_q;
	logic [12:0]   cnt_q;
	logic [LW-1:0] len_q, run_q, rem_q, held_q;
	logic [CW-1:0] rec_q;
	logic [PW-1:0] begin_q, mk_q;
	logic          mv_q;
	logic [RW-1:0] slot_q;
	logic [PW-1:0] rstart_q;
	logic [3:0]    rtype_q;
	logic [31:0]   rid_q;
	status_t       st_q;
	logic [19:0]   res_q;
	logic          sv_s1;
	logic [SW-1:0] spos_s1;
	logic          out_valid_q;
	status_t       status_q;
	logic [19:0]   olab_q;
	logic [12:0]   tot_q;
	logic [8:0]    recs_q;

	logic            pool_we, pool_wd, pool_rd;
	logic [PW-1:0]   pool_wa;
	logic            vld_we, vld_wd, vld_rd;
	logic [RW-1:0]   vld_wa;
	logic            rec_we;
	logic [RECW-1:0] rec_rd;
	logic [PW-1:0]   rd_start;
	logic [LW-1:0]   rd_len;
	logic [3:0]      rd_type;
	logic [31:0]     rd_id;
	logic            scanning, stop_now, issue;
	logic [20:0]     diff;
	logic            in_pool, cvalid;
	logic [PW-1:0]   idx;
	logic [17:0]     rend;

	lpra_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_pool (
		.clk(clk), .we(pool_we), .waddr(pool_wa), .wdata(pool_wd),
		.raddr(sp_q[PW-1:0]), .rdata(pool_rd)
	);

	lpra_ram #(.WIDTH(1), .DEPTH(MAX_RECORDS)) u_valid (
		.clk(clk), .we(vld_we), .waddr(vld_wa), .wdata(vld_wd),
		.raddr(sp_q[RW-1:0]), .rdata(vld_rd)
	);

	lpra_ram #(.WIDTH(RECW), .DEPTH(MAX_RECORDS)) u_rec (
		.clk(clk), .we(rec_we), .waddr(slot_q),
		.wdata({begin_q, len_q, ctype_q, cid_q}),
		.raddr(sp_q[RW-1:0]), .rdata(rec_rd)
	);

	assign {rd_start, rd_len, rd_type, rd_id} = rec_rd;

	assign pool_we = (state_q == S_CLR && clr_q < SW'(POOL_SIZE)) || state_q == S_MARK;
	assign pool_wa = (state_q == S_CLR) ? clr_q[PW-1:0] : mk_q;
	assign pool_wd = (state_q == S_CLR) ? 1'b0 : mv_q;

	function automatic logic rd_len_ok_n();
		return len_q != LW'(1);
	endfunction

	always_comb begin
		vld_we = 1'b0;
		vld_wa = slot_q;
		vld_wd = 1'b0;
		if (state_q == S_CLR) begin
			vld_we = clr_q < SW'(MAX_RECORDS);
			vld_wa = clr_q[RW-1:0];
		end else if (state_q == S_WR) begin
			vld_we = 1'b1;
			vld_wd = 1'b1;
		end else if (state_q == S_OWN && !(req_q == REQ_RELEASE_LABEL && rd_len_ok_n())
				&& rtype_q == ctype_q && rid_q == cid_q) begin
			vld_we = 1'b1;
		end
	end

	assign rec_we = (state_q == S_WR);

	assign diff    = {1'b0, lab_q} - {1'b0, base_q};
	assign in_pool = !diff[20] && (diff < 21'(POOL_SIZE));
	assign idx     = diff[PW-1:0];
	assign cvalid  = (ctype_q != 4'd0) && (32'(ctype_q) < 32'(NUM_CLIENT_TYPES));
	assign rend    = 18'(idx) + 18'(cnt_q);

	assign scanning = state_q == S_FIT || state_q == S_RUN
		|| state_q == S_SLOT || state_q == S_FIND;

	always_comb begin
		stop_now = 1'b0;
		if (sv_s1) begin
			case (state_q)
				S_FIT:   stop_now = (!pool_rd && run_q + LW'(1) == len_q) || spos_s1 == end_q;
				S_RUN:   stop_now = pool_rd || spos_s1 == end_q;
				S_SLOT:  stop_now = !vld_rd || spos_s1 == end_q;
				S_FIND:  stop_now = (vld_rd && rd_start == idx) || spos_s1 == end_q;
				default: stop_now = 1'b0;
			endcase
		end
	end

	assign issue = scanning && !stop_now && sp_q <= end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			base_q      <= 20'd1;
			held_q      <= '0;
			rec_q       <= '0;
			sv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			sv_s1   <= issue;
			spos_s1 <= sp_q;
			if (issue) begin
				sp_q <= sp_q + SW'(1);
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						ctype_q <= client_type;
						cid_q   <= client_id;
						lab_q   <= label;
						cnt_q   <= count;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					res_q   <= '0;
					st_q    <= ST_INVALID;
					state_q <= S_DONE;
					run_q   <= '0;
					sp_q    <= '0;
					end_q   <= SW'(MAX_RECORDS - 1);
					len_q   <= LW'(1);
					if (cvalid) begin
						case (req_q)
							REQ_ALLOC_LABEL: begin
								end_q   <= SW'(POOL_SIZE - 1);
								state_q <= S_FIT;
							end
							REQ_RESERVE_LABEL: begin
								if (!in_pool) begin
									st_q <= ST_RANGE;
								end else begin
									sp_q    <= SW'(idx);
									end_q   <= SW'(idx);
									state_q <= S_RUN;
								end
							end
							REQ_ALLOC_RANGE: begin
								if (cnt_q == 13'd0) begin
									st_q <= ST_INVALID;
								end else if (18'(cnt_q) > 18'(POOL_SIZE)) begin
									st_q <= ST_RANGE;
								end else begin
									len_q   <= LW'(cnt_q);
									end_q   <= SW'(POOL_SIZE - 1);
									state_q <= S_FIT;
								end
							end
							REQ_RESERVE_RANGE: begin
								if (cnt_q == 13'd0) begin
									st_q <= ST_INVALID;
								end else if (!in_pool || rend > 18'(POOL_SIZE)) begin
									st_q <= ST_RANGE;
								end else begin
									len_q   <= LW'(cnt_q);
									sp_q    <= SW'(idx);
									end_q   <= SW'(rend - 18'd1);
									state_q <= S_RUN;
								end
							end
							REQ_RELEASE_LABEL, REQ_RELEASE_RANGE: begin
								if (!in_pool) begin
									st_q <= ST_RANGE;
								end else begin
									state_q <= S_FIND;
								end
							end
							default: st_q <= ST_INVALID;
						endcase
					end
				end
				S_FIT: begin
					if (sv_s1) begin
						if (pool_rd) begin
							run_q <= '0;
						end else begin
							run_q <= run_q + LW'(1);
							if (run_q == '0) begin
								begin_q <= spos_s1[PW-1:0];
							end
						end
						if (stop_now) begin
							sp_q  <= '0;
							end_q <= SW'(MAX_RECORDS - 1);
							if (!pool_rd && run_q + LW'(1) == len_q) begin
								state_q <= S_SLOT;
							end else begin
								st_q    <= ST_NONE_FREE;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_RUN: begin
					if (stop_now) begin
						sp_q    <= '0;
						end_q   <= SW'(MAX_RECORDS - 1);
						begin_q <= idx;
						if (pool_rd) begin
							st_q    <= (req_q == REQ_RESERVE_LABEL) ? ST_IN_USE : ST_BUSY;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SLOT;
						end
					end
				end
				S_SLOT: begin
					if (stop_now) begin
						if (!vld_rd) begin
							slot_q  <= spos_s1[RW-1:0];
							state_q <= S_WR;
						end else begin
							st_q    <= ST_TABLE_FULL;
							state_q <= S_DONE;
						end
					end
				end
				S_FIND: begin
					if (stop_now) begin
						if (vld_rd && rd_start == idx) begin
							slot_q   <= spos_s1[RW-1:0];
							rstart_q <= rd_start;
							len_q    <= rd_len;
							rtype_q  <= rd_type;
							rid_q    <= rd_id;
							state_q  <= S_OWN;
						end else begin
							st_q    <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end
					end
				end
				S_OWN: begin
					if (req_q == REQ_RELEASE_LABEL && rd_len_ok_n()) begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end else if (rtype_q != ctype_q || rid_q != cid_q) begin
						st_q    <= ST_WRONG_OWNER;
						state_q <= S_DONE;
					end else begin
						st_q    <= ST_OK;
						held_q  <= held_q - len_q;
						rec_q   <= rec_q - CW'(1);
						mk_q    <= rstart_q;
						rem_q   <= len_q;
						mv_q    <= 1'b0;
						state_q <= S_MARK;
					end
				end
				S_WR: begin
					st_q    <= ST_OK;
					held_q  <= held_q + len_q;
					rec_q   <= rec_q + CW'(1);
					mk_q    <= begin_q;
					rem_q   <= len_q;
					mv_q    <= 1'b1;
					if (req_q == REQ_ALLOC_LABEL || req_q == REQ_ALLOC_RANGE) begin
						res_q <= 20'(21'(base_q) + 21'(begin_q));
					end
					state_q <= S_MARK;
				end
				S_MARK: begin
					mk_q  <= mk_q + PW'(1);
					rem_q <= rem_q - LW'(1);
					if (rem_q == LW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						olab_q      <= (st_q == ST_OK) ? res_q : 20'd0;
						tot_q       <= 13'(held_q);
						recs_q      <= 9'(rec_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign out_label       = olab_q;
	assign allocated_total = tot_q;
	assign record_total    = recs_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_q) <= 32'(POOL_SIZE)) else $error("held count above pool size");
	a_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rec_q) <= 32'(MAX_RECORDS)) else $error("record count above table size");
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_CHK) else $error("accepted word not checked");
	a_mark_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> rem_q != '0) else $error("mark pass with no length left");
endmodule
